// ===== rtl/core/u2u16_pkg.sv =====
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
`default_nettype none

package u2u16_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // take the input byte into the queue
    logic step;    // decode one sequence at the head of the queue
    logic finish;  // close the byte: update halt state and pending bytes
    logic emit;    // move one buffered unit into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;        // nothing more can be decoded for this byte
    logic has_units;   // at least one unit is buffered
    logic out_free;    // the output register can take a unit this cycle
    logic drain_last;  // the unit to be emitted is the final one
  } status_t;

  localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
  localparam logic [7:0]  LEAD2_TAG   = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
  localparam logic [7:0]  LEAD3_TAG   = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK  = 8'hF8;
  localparam logic [7:0]  LEAD4_TAG   = 8'hF0;
  localparam logic [7:0]  CONT_MASK   = 8'hC0;
  localparam logic [7:0]  CONT_TAG    = 8'h80;
  localparam logic [20:0] MIN_CODE2   = 21'h00080;
  localparam logic [20:0] MIN_CODE3   = 21'h00800;
  localparam logic [20:0] MIN_CODE4   = 21'h10000;
  localparam logic [20:0] MAX_CODE    = 21'h10FFFF;
  localparam logic [20:0] SURR_LOW    = 21'h0D800;
  localparam logic [20:0] SURR_HIGH   = 21'h0DFFF;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;

endpackage

`default_nettype wire

// ===== rtl/core/u2u16_ctrl.sv =====
// Controller state machine of the transcoder: accept, decode, drain.
`default_nettype none

module u2u16_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  u2u16_pkg::status_t     status,
  output u2u16_pkg::cmd_t        cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.done) begin
          cmd.finish = 1'b1;
          state_next = status.has_units ? ST_DRAIN : ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DRAIN: begin
        // The final unit may still sit in the output register while the next
        // byte is taken.
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.drain_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u2u16_datapath.sv =====
// Datapath of the transcoder: byte queue, sequence decoder, unit buffer, output register.
`default_nettype none

module u2u16_datapath #(
  parameter int DRAFT_UNITS = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  u2u16_pkg::cmd_t        cmd,
  output u2u16_pkg::status_t     status,
  input  wire logic [7:0]        text_byte,
  input  wire logic              first_of_text,
  input  wire logic              end_of_text,
  input  wire logic [7:0]        free_units,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [15:0]            utf16_unit,
  output logic                   last_of_run
);

  localparam int RW = $clog2(DRAFT_UNITS + 1);
  localparam int CW = (RW > 8) ? RW : 8;

  // Byte queue: held bytes followed by the new byte, head at entry 0.
  logic [7:0]    q [4];
  logic [2:0]    qlen;
  logic [RW-1:0] room;
  logic          halted;
  logic          eot;
  logic [15:0]   ubuf [3];
  logic [1:0]    ucount;
  logic [1:0]    rd_idx;

  logic [RW-1:0] load_room;
  logic          load_halt;

  logic [7:0]    head;
  logic [2:0]    len;
  logic          cont_bad;
  logic [20:0]   code;
  logic [19:0]   supp;
  logic          code_bad;
  logic          incomplete;
  logic [2:0]    sh;
  logic [1:0]    n_emit;
  logic [15:0]   u0;
  logic [15:0]   u1;
  logic [RW-1:0] room_dec;

  always_comb begin
    if (CW'(free_units) > CW'(DRAFT_UNITS)) begin
      load_room = RW'(DRAFT_UNITS);
    end else begin
      load_room = RW'(free_units);
    end
    if (first_of_text) begin
      load_halt = (load_room == '0);
    end else begin
      load_halt = halted;
    end
  end

  // Decode of the sequence at the head of the queue.
  always_comb begin
    head = q[0];
    if (!head[7]) begin
      len = 3'd1;
    end else if ((head & u2u16_pkg::LEAD2_MASK) == u2u16_pkg::LEAD2_TAG) begin
      len = 3'd2;
    end else if ((head & u2u16_pkg::LEAD3_MASK) == u2u16_pkg::LEAD3_TAG) begin
      len = 3'd3;
    end else if ((head & u2u16_pkg::LEAD4_MASK) == u2u16_pkg::LEAD4_TAG) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end

    incomplete = (len >= 3'd2) && (qlen < len);
    cont_bad = ((len >= 3'd2) && ((q[1] & u2u16_pkg::CONT_MASK) != u2u16_pkg::CONT_TAG)) ||
               ((len >= 3'd3) && ((q[2] & u2u16_pkg::CONT_MASK) != u2u16_pkg::CONT_TAG)) ||
               ((len == 3'd4) && ((q[3] & u2u16_pkg::CONT_MASK) != u2u16_pkg::CONT_TAG));

    case (len)
      3'd2:    code = {10'd0, head[4:0], q[1][5:0]};
      3'd3:    code = {5'd0, head[3:0], q[1][5:0], q[2][5:0]};
      3'd4:    code = {head[2:0], q[1][5:0], q[2][5:0], q[3][5:0]};
      default: code = {13'd0, head};
    endcase

    code_bad = ((len == 3'd2) && (code < u2u16_pkg::MIN_CODE2)) ||
               ((len == 3'd3) && (code < u2u16_pkg::MIN_CODE3)) ||
               ((len == 3'd4) && (code < u2u16_pkg::MIN_CODE4)) ||
               (code > u2u16_pkg::MAX_CODE) ||
               ((code >= u2u16_pkg::SURR_LOW) && (code <= u2u16_pkg::SURR_HIGH));

    supp = 20'(code - u2u16_pkg::MIN_CODE4);
    u0   = code[15:0];
    u1   = u2u16_pkg::LO_SURR_BASE | {6'd0, supp[9:0]};
    n_emit   = 2'd0;
    room_dec = '0;
    sh       = 3'd1;

    if (len == 3'd1) begin
      n_emit   = 2'd1;
      room_dec = RW'(1);
    end else if (len != 3'd0 && !cont_bad) begin
      sh = len;
      if (!code_bad) begin
        if (code[20:16] == 5'd0) begin
          n_emit   = 2'd1;
          room_dec = RW'(1);
        end else if (room >= RW'(2)) begin
          n_emit   = 2'd2;
          room_dec = RW'(2);
          u0       = u2u16_pkg::HI_SURR_BASE | {6'd0, supp[19:10]};
        end
      end
    end
  end

  always_comb begin
    status.done       = (qlen == 3'd0) || (room == '0) || incomplete;
    status.has_units  = (ucount != 2'd0);
    status.out_free   = !out_valid || !out_stall;
    status.drain_last = (rd_idx == (ucount - 2'd1));
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      qlen   <= 3'd0;
      room   <= '0;
      halted <= 1'b0;
      ucount <= 2'd0;
      rd_idx <= 2'd0;
    end else begin
      if (cmd.load) begin
        ucount <= 2'd0;
        if (first_of_text) begin
          room <= load_room;
        end
        halted <= load_halt;
        if (load_halt || first_of_text) begin
          qlen <= load_halt ? 3'd0 : 3'd1;
        end else begin
          qlen <= qlen + 3'd1;
        end
      end
      if (cmd.step) begin
        qlen   <= qlen - sh;
        room   <= room - room_dec;
        ucount <= ucount + n_emit;
      end
      if (cmd.finish) begin
        rd_idx <= 2'd0;
        if (room == '0 || eot) begin
          qlen   <= 3'd0;
          halted <= 1'b1;
        end
      end
      if (cmd.emit) begin
        rd_idx <= rd_idx + 2'd1;
      end
    end
  end

  // Queue contents and unit buffer need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      eot <= end_of_text;
      if (first_of_text) begin
        q[0] <= text_byte;
      end else begin
        q[qlen[1:0]] <= text_byte;
      end
    end
    if (cmd.step) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) + sh < 3'd4) begin
          q[i] <= q[2'(3'(i) + sh)];
        end
      end
      if (n_emit != 2'd0 && ucount != 2'd3) begin
        ubuf[ucount] <= u0;
      end
      if (n_emit == 2'd2 && ucount < 2'd2) begin
        ubuf[ucount + 2'd1] <= u1;
      end
    end
    if (cmd.emit && rd_idx != 2'd3) begin
      utf16_unit  <= ubuf[rd_idx];
      last_of_run <= status.drain_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder.
//
// Input channel: one UTF-8 byte per transfer with in_valid/in_stall, plus the
// first_of_text and end_of_text marks and the destination room free_units,
// which is sampled only with the first byte and saturates at DRAFT_UNITS.
// Output channel: one UTF-16 unit per transfer with out_valid/out_stall;
// last_of_run marks the final unit caused by one input byte. A byte may cause
// zero to three units.
// Operation: a byte is taken into the queue, then the decoder steps through the
// sequences at the head of its four-byte queue, closes the byte, and moves the
// units one per cycle into the output register while the output does not stall.
// The worst case is a replay of three held bytes that yields three units.
// in_stall is high while a byte is decoded or its units are drained; the last
// unit may wait in the output register while the next byte is taken.
// A stall on the output holds the unit and freezes the drain.
// Reset clears the queue, the room and the halt state; before the first
// marked byte every byte is consumed with no output.
`default_nettype none

module utf8_to_utf16_transcoder #(
  parameter int DRAFT_UNITS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        first_of_text,
  input  wire logic        end_of_text,
  input  wire logic [7:0]  free_units,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      utf16_unit,
  output logic             last_of_run
);

  u2u16_pkg::cmd_t    cmd;
  u2u16_pkg::status_t status;

  u2u16_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  u2u16_datapath #(
    .DRAFT_UNITS (DRAFT_UNITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .text_byte     (text_byte),
    .first_of_text (first_of_text),
    .end_of_text   (end_of_text),
    .free_units    (free_units),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .utf16_unit    (utf16_unit),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire

// ===== rtl/core/u2u16_checker.sv =====
// Port-level checks of the transcoder and their binding to the top level.
`default_nettype none

module u2u16_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] utf16_unit,
  input wire logic        last_of_run
);

  // A stalled unit stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(utf16_unit) && $stable(last_of_run))
    else $error("output unit changed while stalled");

  // The block works on one byte at a time.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a byte was in work");

  // Units of one byte follow one another without a gap.
  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("gap inside a run of units");

  // A high surrogate is always followed by its low half.
  a_pair_whole: assert property (@(posedge clk) disable iff (rst)
    out_valid && (utf16_unit[15:10] == u2u16_pkg::HI_SURR_TAG) |-> !last_of_run)
    else $error("high surrogate closed a run");

endmodule

bind utf8_to_utf16_transcoder u2u16_checker u_u2u16_checker (.*);

`default_nettype wire

// ===== tb/sv/utf8_to_utf16_transcoder_tb.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 transcoder with a built-in decoder predictor.
`default_nettype none

module utf8_to_utf16_transcoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAFT_UNITS = 128;
  localparam int CALM_TAIL   = 40;

  typedef struct {
    logic [7:0] data;
    logic       starts;
    logic       ends;
    logic [7:0] room;
  } text_byte_t;

  typedef struct {
    logic [15:0] code_unit;
    logic        closes;
  } utf16_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  text_byte = 8'h00;
  logic        first_of_text = 1'b0;
  logic        end_of_text = 1'b0;
  logic [7:0]  free_units = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] utf16_unit;
  logic        last_of_run;

  utf8_to_utf16_transcoder #(.DRAFT_UNITS(DRAFT_UNITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .text_byte(text_byte), .first_of_text(first_of_text),
    .end_of_text(end_of_text), .free_units(free_units),
    .out_valid(out_valid), .out_stall(out_stall),
    .utf16_unit(utf16_unit), .last_of_run(last_of_run)
  );

  always #2 clk = ~clk;

  text_byte_t  byte_q[$];
  text_byte_t  cur_byte;
  utf16_exp_t  unit_q[$];
  utf16_exp_t  want;
  logic [7:0]  text_buf[$];

  // Predictor state of the decoder.
  logic [7:0]  held_bytes[3];
  int unsigned held_cnt = 0;
  int unsigned room_units = 0;
  logic        is_halted = 1'b0;

  int unsigned n_items = 0;
  int unsigned n_taken = 0;
  int unsigned n_texts = 0;
  int unsigned n_units = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  logic        calm;

  // Idling comes in stretches; none starts during the final bytes of the run.
  assign calm = ((n_cycles / 200) % 3 == 2) || (n_taken + CALM_TAIL >= n_items);

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic append_text(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endtask

  task automatic decode_byte(input text_byte_t it);
    logic [7:0]  win[4];
    logic [15:0] got[4];
    logic [7:0]  lead;
    logic        bad;
    utf16_exp_t  exp_unit;
    int unsigned wlen, pos, seq, code, n, k;
    n = 0;
    if (it.starts) begin
      room_units = (it.room > DRAFT_UNITS) ? DRAFT_UNITS : it.room;
      held_cnt = 0;
      is_halted = (room_units == 0);
    end
    if (is_halted) begin
      held_cnt = 0;
    end else begin
      for (k = 0; k < held_cnt; k++) win[k] = held_bytes[k];
      win[held_cnt] = it.data;
      wlen = held_cnt + 1;
      pos = 0;
      while (pos < wlen && room_units > 0) begin
        lead = win[pos];
        if (lead < 8'h80) seq = 1;
        else if ((lead & u2u16_pkg::LEAD2_MASK) == u2u16_pkg::LEAD2_TAG) seq = 2;
        else if ((lead & u2u16_pkg::LEAD3_MASK) == u2u16_pkg::LEAD3_TAG) seq = 3;
        else if ((lead & u2u16_pkg::LEAD4_MASK) == u2u16_pkg::LEAD4_TAG) seq = 4;
        else seq = 0;
        if (seq == 0) begin
          pos++;
        end else if (seq == 1) begin
          got[n] = {8'h00, lead};
          n++;
          room_units--;
          pos++;
        end else if (wlen - pos < seq) begin
          break;
        end else begin
          code = lead & (seq == 2 ? 8'h1F : seq == 3 ? 8'h0F : 8'h07);
          bad = 1'b0;
          for (k = 1; k < seq; k++) begin
            if ((win[pos + k] & u2u16_pkg::CONT_MASK) != u2u16_pkg::CONT_TAG) bad = 1'b1;
            code = (code << 6) | (win[pos + k] & 8'h3F);
          end
          // A broken continuation costs only the lead; the rest is decoded again.
          if (bad) begin
            pos++;
          end else begin
            if ((seq == 2 && code < u2u16_pkg::MIN_CODE2) ||
                (seq == 3 && code < u2u16_pkg::MIN_CODE3) ||
                (seq == 4 && code < u2u16_pkg::MIN_CODE4) ||
                code > u2u16_pkg::MAX_CODE ||
                (code >= u2u16_pkg::SURR_LOW && code <= u2u16_pkg::SURR_HIGH)) begin
              // Overlong, surrogate or beyond the code space: dropped whole.
            end else if (code <= 32'hFFFF) begin
              got[n] = code[15:0];
              n++;
              room_units--;
            end else if (room_units >= 2) begin
              code = code - 32'h10000;
              got[n] = u2u16_pkg::HI_SURR_BASE + code[19:10];
              got[n + 1] = u2u16_pkg::LO_SURR_BASE + code[9:0];
              n += 2;
              room_units -= 2;
            end
            pos += seq;
          end
        end
      end
      held_cnt = 0;
      if (room_units == 0) begin
        is_halted = 1'b1;
      end else begin
        for (k = pos; k < wlen && held_cnt < 3; k++) begin
          held_bytes[held_cnt] = win[k];
          held_cnt++;
        end
      end
      if (it.ends) begin
        held_cnt = 0;
        is_halted = 1'b1;
      end
      for (k = 0; k < n; k++) begin
        exp_unit.code_unit = got[k];
        exp_unit.closes = (k == n - 1);
        unit_q.insert(unit_q.size(), exp_unit);
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic starts, input logic ends,
                            input logic [7:0] room);
    text_byte_t it;
    it.data = data;
    it.starts = starts;
    it.ends = ends;
    it.room = room;
    byte_q.insert(byte_q.size(), it);
    n_items++;
  endtask

  // Sends the bytes in text_buf as one text; bytes other than the first carry random room.
  task automatic flush_text(input logic [7:0] room, input logic with_end);
    int unsigned k;
    for (k = 0; k < text_buf.size(); k++) begin
      queue_byte(text_buf[k], k == 0, with_end && (k == text_buf.size() - 1),
                 (k == 0) ? room : 8'($urandom_range(0, 255)));
    end
    text_buf.delete();
    n_texts++;
  endtask

  // Driver: a new byte is presented only when none is pending or the last one was taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(cur_byte);
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else begin
          cur_byte = byte_q.pop_front();
          text_byte <= cur_byte.data;
          first_of_text <= cur_byte.starts;
          end_of_text <= cur_byte.ends;
          free_units <= cur_byte.room;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor and output stall bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      n_cycles++;
      if (out_valid && !out_stall) begin
        if (unit_q.size() == 0) begin
          note_mismatch($sformatf("unexpected unit %h", utf16_unit));
        end else begin
          want = unit_q.pop_front();
          if (utf16_unit !== want.code_unit)
            note_mismatch($sformatf("utf16_unit %h, expected %h", utf16_unit, want.code_unit));
          if (last_of_run !== want.closes)
            note_mismatch($sformatf("last_of_run %b, expected %b on unit %h",
                                    last_of_run, want.closes, want.code_unit));
          n_units++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned target, chars, c, kind, cp;
    logic [7:0] room;

    // Bytes before any text start are swallowed.
    queue_byte(8'h41, 1'b0, 1'b0, 8'hFF);
    queue_byte(8'hC3, 1'b0, 1'b0, 8'h00);

    // Room above the draft size, every sequence length, invalid leads, overlong,
    // surrogate and out-of-range codes, lead replay and a sequence cut off at the end.
    text_buf = {8'h41, 8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF, 8'hC0, 8'h80,
                8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
                8'hF0, 8'h41, 8'h42, 8'h43, 8'hE2, 8'h82};
    flush_text(8'hFF, 1'b1);
    // One unit of room: the pair is skipped, the next character fills the room.
    text_buf = {8'hF0, 8'h9F, 8'h98, 8'h80, 8'h42, 8'h43};
    flush_text(8'h01, 1'b1);
    // No room at all.
    text_buf = {8'h41, 8'h42};
    flush_text(8'h00, 1'b1);

    target = n_items + 410;
    while (n_items < target) begin
      case ($urandom_range(0, 9))
        0: room = 8'h00;
        1: room = 8'h01;
        2: room = 8'h02;
        3: room = 8'($urandom_range(129, 255));
        4: room = 8'd128;
        default: room = 8'($urandom_range(3, 40));
      endcase
      chars = $urandom_range(1, 12);
      for (c = 0; c < chars; c++) begin
        kind = $urandom_range(0, 19);
        if (kind <= 5) begin
          append_text(8'($urandom_range(0, 127)));
        end else if (kind <= 9) begin
          cp = $urandom_range(32'h80, 32'h7FF);
          append_text(8'hC0 | 8'(cp >> 6));
          append_text(8'h80 | 8'(cp & 32'h3F));
        end else if (kind <= 13) begin
          cp = $urandom_range(32'h800, 32'hFFFF);
          if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp + 32'h800;
          append_text(8'hE0 | 8'(cp >> 12));
          append_text(8'h80 | 8'((cp >> 6) & 32'h3F));
          append_text(8'h80 | 8'(cp & 32'h3F));
        end else if (kind <= 16) begin
          cp = $urandom_range(32'h10000, 32'h10FFFF);
          append_text(8'hF0 | 8'(cp >> 18));
          append_text(8'h80 | 8'((cp >> 12) & 32'h3F));
          append_text(8'h80 | 8'((cp >> 6) & 32'h3F));
          append_text(8'h80 | 8'(cp & 32'h3F));
        end else if (kind == 17) begin
          append_text(8'($urandom_range(0, 255)));
        end else if (kind == 18) begin
          // A lead whose continuations are missing.
          append_text(8'($urandom_range(8'hC2, 8'hF4)));
        end else begin
          case ($urandom_range(0, 3))
            0: begin
              append_text(8'($urandom_range(8'hC0, 8'hC1)));
              append_text(8'($urandom_range(8'h80, 8'hBF)));
            end
            1: begin
              append_text(8'hE0);
              append_text(8'($urandom_range(8'h80, 8'h9F)));
              append_text(8'($urandom_range(8'h80, 8'hBF)));
            end
            2: begin
              append_text(8'hED);
              append_text(8'($urandom_range(8'hA0, 8'hBF)));
              append_text(8'($urandom_range(8'h80, 8'hBF)));
            end
            default: begin
              append_text(8'($urandom_range(8'hF4, 8'hF7)));
              append_text(8'($urandom_range(8'h90, 8'hBF)));
              append_text(8'($urandom_range(8'h80, 8'hBF)));
              append_text(8'($urandom_range(8'h80, 8'hBF)));
            end
          endcase
        end
      end
      flush_text(room, $urandom_range(0, 7) != 0);
      // A stray byte after a text; it must be ignored if the text was ended.
      if ($urandom_range(0, 4) == 0)
        queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 8'hFF);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    wait (n_taken == n_items);
    while (unit_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d bytes in %0d texts, checked %0d UTF-16 units, %0d mismatches",
             n_taken, n_texts, n_units, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d of %0d bytes taken and %0d units outstanding",
             n_taken, n_items, unit_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/u2u16_pkg.sv
rtl/core/u2u16_ctrl.sv
rtl/core/u2u16_datapath.sv
rtl/core/utf8_to_utf16_transcoder.sv
rtl/core/u2u16_checker.sv
tb/sv/utf8_to_utf16_transcoder_tb.sv
